### rtl/core/imufd_pkg.sv
// imufd_pkg: shared constants and types for the IMU frame decoder.
// No dependencies; imported by every module under rtl/core.
package imufd_pkg;

  localparam int FRAME_LENGTH = 11;
  localparam int POS_W        = $clog2(FRAME_LENGTH);
  localparam int STORE_DEPTH  = 10;
  localparam int STORE_IDX_W  = $clog2(STORE_DEPTH);

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LENGTH - 1);

  localparam logic [7:0] HEADER_BYTE = 8'h55;
  localparam logic [7:0] TYPE_ACCEL  = 8'h51;
  localparam logic [7:0] TYPE_RATE   = 8'h52;

  localparam logic KIND_ACCEL = 1'b0;
  localparam logic KIND_RATE  = 1'b1;

  localparam int GAIN_W   = 24;
  localparam int RAW_W    = 16;
  localparam int SCALED_W = 40;

  localparam logic CFG_ACCEL_GAIN = 1'b0;
  localparam logic CFG_RATE_GAIN  = 1'b1;

  // Decoded-frame queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic                    kind;
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;
  } frame_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### rtl/core/imufd_front.sv
// imufd_front: byte collector and frame classifier.
// Depends on imufd_pkg; pushes decoded frames into imufd_queue.
module imufd_front import imufd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  input  logic [7:0] rx_byte,
  output logic       rec_push,
  output frame_rec_t rec
);

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic [7:0]       frame_bytes [STORE_DEPTH];
  logic             bad_header;
  logic             is_last;
  logic [7:0]       type_byte;

  assign bad_header = (pos == '0) && (rx_byte != HEADER_BYTE);
  assign is_last    = (pos == LAST_POS);
  // Type and axis bytes are all stored before the final byte arrives
  assign type_byte  = frame_bytes[1];

  always_comb begin
    pos_next = pos;
    if (byte_valid) begin
      if (bad_header || is_last) begin
        pos_next = '0;
      end else begin
        pos_next = pos + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !bad_header && (32'(pos) < STORE_DEPTH)) begin
      frame_bytes[pos[STORE_IDX_W-1:0]] <= rx_byte;
    end
  end

  assign rec_push = byte_valid && is_last &&
                    ((type_byte == TYPE_ACCEL) || (type_byte == TYPE_RATE));

  assign rec.kind  = (type_byte == TYPE_RATE) ? KIND_RATE : KIND_ACCEL;
  assign rec.raw_x = {frame_bytes[3], frame_bytes[2]};
  assign rec.raw_y = {frame_bytes[5], frame_bytes[4]};
  assign rec.raw_z = {frame_bytes[7], frame_bytes[6]};

endmodule

### rtl/core/imufd_queue.sv
// imufd_queue: short register queue of decoded frames.
// Depends on imufd_pkg; sits between imufd_front and imufd_back.
module imufd_queue import imufd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  frame_rec_t wr_rec,
  input  logic       pop,
  output frame_rec_t rd_rec,
  output q_status_t  status
);

  frame_rec_t        entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign status.full  = (count == QCNT_W'(QDEPTH));
  assign status.empty = (count == '0);
  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;
  assign rd_rec  = entries[rd_ptr];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_rec;
    end
  end

endmodule

### rtl/core/imufd_back.sv
// imufd_back: gain registers, axis scaling multipliers and result register.
// Depends on imufd_pkg; drains imufd_queue.
module imufd_back import imufd_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [GAIN_W-1:0]          cfg_data,
  input  frame_rec_t                 q_rec,
  input  q_status_t                  q_status,
  output logic                       q_pop,
  output logic                       empty,
  input  logic                       pop,
  output logic                       frame_kind,
  output logic signed [RAW_W-1:0]    raw_x,
  output logic signed [RAW_W-1:0]    raw_y,
  output logic signed [RAW_W-1:0]    raw_z,
  output logic signed [SCALED_W-1:0] scaled_x,
  output logic signed [SCALED_W-1:0] scaled_y,
  output logic signed [SCALED_W-1:0] scaled_z
);

  logic [GAIN_W-1:0] accel_gain;
  logic [GAIN_W-1:0] rate_gain;
  logic [GAIN_W-1:0] gain;
  logic              out_valid;
  logic              load;

  // 16 x 25 signed product, exact in 40 bits
  function automatic logic [SCALED_W-1:0] scale(input logic signed [RAW_W-1:0] raw,
                                                input logic [GAIN_W-1:0] g);
    logic signed [SCALED_W:0] prod;
    prod  = $signed(raw) * $signed({1'b0, g});
    scale = prod[SCALED_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_gain <= GAIN_W'(8192);
      rate_gain  <= GAIN_W'(8192);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACCEL_GAIN: accel_gain <= cfg_data;
        CFG_RATE_GAIN:  rate_gain  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign gain  = (q_rec.kind == KIND_RATE) ? rate_gain : accel_gain;
  assign empty = !out_valid;
  // Result register refills in the cycle it is taken
  assign load  = !q_status.empty && (!out_valid || pop);
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_kind <= q_rec.kind;
      raw_x      <= q_rec.raw_x;
      raw_y      <= q_rec.raw_y;
      raw_z      <= q_rec.raw_z;
      scaled_x   <= scale(q_rec.raw_x, gain);
      scaled_y   <= scale(q_rec.raw_y, gain);
      scaled_z   <= scale(q_rec.raw_z, gain);
    end
  end

endmodule

### rtl/core/imu_frame_decoder.sv
// imu_frame_decoder: top level of the 11-byte IMU frame decoder.
// Depends on imufd_pkg, imufd_front, imufd_queue and imufd_back.
//
//  channel  | handshake          | word
//  ---------+--------------------+-----------------------------------------
//  input    | push / full        | rx_byte (one UART byte)
//  result   | empty / pop        | frame_kind, raw_x/y/z, scaled_x/y/z
//  config   | cfg_we (no wait)   | cfg_index (0 accel_gain, 1 rate_gain),
//           |                    | cfg_data (24-bit Q0.24 gain)
//
// One byte is taken per cycle while full is low. A decoded frame goes from
// the front into a two-word queue the cycle its last byte arrives; the back
// lands it, multiplied, in the result register when that is empty or popped.
// The three axis multipliers feed the result register directly, so a result
// can leave every cycle while the queue is not empty. full follows the queue
// only, so bytes keep flowing while a result waits; once the queue fills,
// full holds off further bytes. rst (synchronous) clears the byte position,
// queue and result valid and sets both gains to 8192.
module imu_frame_decoder import imufd_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 rx_byte,
  output logic                       empty,
  input  logic                       pop,
  output logic                       frame_kind,
  output logic signed [RAW_W-1:0]    raw_x,
  output logic signed [RAW_W-1:0]    raw_y,
  output logic signed [RAW_W-1:0]    raw_z,
  output logic signed [SCALED_W-1:0] scaled_x,
  output logic signed [SCALED_W-1:0] scaled_y,
  output logic signed [SCALED_W-1:0] scaled_z,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [GAIN_W-1:0]          cfg_data
);

  frame_rec_t front_rec;
  frame_rec_t q_rec;
  q_status_t  q_status;
  logic       rec_push;
  logic       q_pop;
  logic       byte_valid;

  // Word accepted at the edge where push is high and full is low
  assign full       = q_status.full;
  assign byte_valid = push && !full;

  imufd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .rx_byte    (rx_byte),
    .rec_push   (rec_push),
    .rec        (front_rec)
  );

  imufd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (rec_push),
    .wr_rec (front_rec),
    .pop    (q_pop),
    .rd_rec (q_rec),
    .status (q_status)
  );

  imufd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_rec      (q_rec),
    .q_status   (q_status),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .frame_kind (frame_kind),
    .raw_x      (raw_x),
    .raw_y      (raw_y),
    .raw_z      (raw_z),
    .scaled_x   (scaled_x),
    .scaled_y   (scaled_y),
    .scaled_z   (scaled_z)
  );

endmodule

### bench/testbench.sv
// testbench: self-checking bench for imu_frame_decoder (UART byte in, decoded frame out).
// Needs imufd_pkg and the decoder RTL; an internal frame predictor supplies expected words.
`timescale 1ns / 100ps

module testbench;
  import imufd_pkg::*;

  localparam logic [7:0]  TYPE_OTHER   = 8'h53;   // neither acceleration nor rate
  localparam logic [23:0] GAIN_RESET   = 24'd8192;
  localparam logic [23:0] GAIN_MAX     = 24'hFF_FFFF;
  localparam int          SETTLE_CYCLES = 6;      // queue and result register plus margin
  localparam int          STALL_LIMIT   = 4000;   // cycles with no word moving

  typedef struct {
    logic                       kind;
    logic signed [RAW_W-1:0]    raw_x;
    logic signed [RAW_W-1:0]    raw_y;
    logic signed [RAW_W-1:0]    raw_z;
    logic signed [SCALED_W-1:0] scaled_x;
    logic signed [SCALED_W-1:0] scaled_y;
    logic signed [SCALED_W-1:0] scaled_z;
  } decoded_frame_t;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       push = 1'b0;
  logic                       full;
  logic [7:0]                 rx_byte = 8'h00;
  logic                       empty;
  logic                       pop = 1'b0;
  logic                       frame_kind;
  logic signed [RAW_W-1:0]    raw_x, raw_y, raw_z;
  logic signed [SCALED_W-1:0] scaled_x, scaled_y, scaled_z;
  logic                       cfg_we = 1'b0;
  logic                       cfg_index = CFG_ACCEL_GAIN;
  logic [GAIN_W-1:0]          cfg_data = '0;

  // Predictor state: frame assembly plus a copy of both gain registers
  logic [7:0]     frame_store [STORE_DEPTH];
  int             frame_pos = 0;
  logic [23:0]    accel_gain_q = GAIN_RESET;
  logic [23:0]    rate_gain_q  = GAIN_RESET;
  decoded_frame_t pending_frames [$];

  int error_count = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  imu_frame_decoder i_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .rx_byte    (rx_byte),
    .empty      (empty),
    .pop        (pop),
    .frame_kind (frame_kind),
    .raw_x      (raw_x),
    .raw_y      (raw_y),
    .raw_z      (raw_z),
    .scaled_x   (scaled_x),
    .scaled_y   (scaled_y),
    .scaled_z   (scaled_z),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Frame predictor
  // ---------------------------------------------------------------------------

  // Exact product; magnitude stays below 2^39 so the low 40 bits hold it.
  function automatic logic signed [SCALED_W-1:0] scale_axis(
      input logic signed [RAW_W-1:0] raw, input logic [23:0] gain);
    longint r;
    longint g;
    longint p;
    r = longint'(raw);
    g = longint'(gain);
    p = r * g;
    return p[SCALED_W-1:0];
  endfunction

  // Advance the frame assembler by one accepted byte; queue a word when a
  // known frame type completes.
  function automatic void predict_byte(input logic [7:0] b);
    decoded_frame_t f;
    logic [23:0]    gain;
    // Bad header: stray byte at frame start is dropped
    if (frame_pos == 0 && b != HEADER_BYTE) return;
    // Bytes past the store still count toward the length
    if (frame_pos < STORE_DEPTH) frame_store[STORE_IDX_W'(frame_pos)] = b;
    frame_pos++;
    if (frame_pos < FRAME_LENGTH) return;
    frame_pos = 0;
    if (frame_store[1] == TYPE_ACCEL) begin
      f.kind = KIND_ACCEL;
      gain   = accel_gain_q;
    end else if (frame_store[1] == TYPE_RATE) begin
      f.kind = KIND_RATE;
      gain   = rate_gain_q;
    end else begin
      return;  // unknown type: silently dropped
    end
    f.raw_x    = {frame_store[3], frame_store[2]};
    f.raw_y    = {frame_store[5], frame_store[4]};
    f.raw_z    = {frame_store[7], frame_store[6]};
    f.scaled_x = scale_axis(f.raw_x, gain);
    f.scaled_y = scale_axis(f.raw_y, gain);
    f.scaled_z = scale_axis(f.raw_z, gain);
    pending_frames.push_back(f);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random pop, field-by-field compare, watchdog
  // ---------------------------------------------------------------------------

  always @(negedge clk) pop = ($urandom_range(99) >= stall_pct);

  task automatic check_field(input string name, input logic signed [SCALED_W-1:0] exp_val,
                             input logic signed [SCALED_W-1:0] act_val);
    if (exp_val !== act_val) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    decoded_frame_t f;
    if (!rst && pop && !empty) begin
      if (pending_frames.size() == 0) begin
        error_count++;
        $display("%0t: unexpected word, expected none, actual kind %0d raw %0d %0d %0d",
                 $time, frame_kind, raw_x, raw_y, raw_z);
      end else begin
        f = pending_frames.pop_front();
        check_field("frame_kind", SCALED_W'(f.kind), SCALED_W'(frame_kind));
        check_field("raw_x", SCALED_W'(f.raw_x), SCALED_W'(raw_x));
        check_field("raw_y", SCALED_W'(f.raw_y), SCALED_W'(raw_y));
        check_field("raw_z", SCALED_W'(f.raw_z), SCALED_W'(raw_z));
        check_field("scaled_x", f.scaled_x, scaled_x);
        check_field("scaled_y", f.scaled_y, scaled_y);
        check_field("scaled_z", f.scaled_z, scaled_z);
      end
    end
  end

  // Any word moving on either side resets the count
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, %0d words still expected", $time, pending_frames.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one byte, with random idle cycles first; returns at the accepting edge
  // with push still high so back-to-back bytes need no gap.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      push    = 1'b0;
      rx_byte = 8'($urandom_range(255));
      @(negedge clk);
    end
    push    = 1'b1;
    rx_byte = b;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_byte(b);
  endtask

  task automatic send_frame(input logic [7:0] frame_type, input logic [15:0] x,
                            input logic [15:0] y, input logic [15:0] z);
    send_byte(HEADER_BYTE);
    send_byte(frame_type);
    send_byte(x[7:0]);
    send_byte(x[15:8]);
    send_byte(y[7:0]);
    send_byte(y[15:8]);
    send_byte(z[7:0]);
    send_byte(z[15:8]);
    // trailing bytes, checksum last; never checked
    for (int i = 8; i < FRAME_LENGTH; i++) send_byte(8'($urandom_range(255)));
  endtask

  // Hold off input until every expected word is out and the pipeline is quiet
  task automatic drain();
    @(negedge clk);
    push = 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gain(input logic index, input logic [23:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_data  = value;
    @(negedge clk);
    cfg_we   = 1'b0;
    cfg_data = GAIN_W'($urandom_range(GAIN_MAX));
    if (index == CFG_ACCEL_GAIN) accel_gain_q = value;
    else rate_gain_q = value;
  endtask

  function automatic logic [7:0] pick_type();
    logic [7:0] t;
    if ($urandom_range(9) != 0) return $urandom_range(1) ? TYPE_RATE : TYPE_ACCEL;
    do t = 8'($urandom_range(255)); while (t == TYPE_ACCEL || t == TYPE_RATE);
    return t;
  endfunction

  // Mostly whole frames; some truncated frames and some stray bytes to force
  // the assembler out of step and back again.
  task automatic send_traffic(input int n_bytes);
    int sent;
    int pick;
    int len;
    sent = 0;
    while (sent < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        send_frame(pick_type(), 16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                   16'($urandom_range(16'hFFFF)));
        sent += FRAME_LENGTH;
      end else if (pick < 90) begin
        len = $urandom_range(FRAME_LENGTH - 1, 1);
        send_byte(HEADER_BYTE);
        repeat (len - 1) send_byte(8'($urandom_range(255)));
        sent += len;
      end else begin
        len = $urandom_range(4, 1);
        repeat (len) send_byte(8'($urandom_range(255)));
        sent += len;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset gains, stray header bytes, axis extremes, both kinds, unknown type
  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_byte(8'h00);
    send_byte(8'hAA);
    send_frame(TYPE_ACCEL, 16'h7FFF, 16'h8000, 16'h0000);
    send_frame(TYPE_RATE, 16'hFFFF, 16'h0001, 16'h8000);
    send_frame(TYPE_OTHER, 16'h1234, 16'h5678, 16'h9ABC);
    drain();
  endtask

  // Zero and full-scale gain on each register
  task automatic test_gain_extremes();
    write_gain(CFG_ACCEL_GAIN, '0);
    write_gain(CFG_RATE_GAIN, GAIN_MAX);
    send_frame(TYPE_ACCEL, 16'h8000, 16'h7FFF, 16'hFFFF);
    send_frame(TYPE_RATE, 16'h8000, 16'h7FFF, 16'hFFFF);
    send_traffic(120);
    drain();
    write_gain(CFG_ACCEL_GAIN, GAIN_MAX);
    write_gain(CFG_RATE_GAIN, '0);
    send_frame(TYPE_ACCEL, 16'h8000, 16'h7FFF, 16'hFFFF);
    send_frame(TYPE_RATE, 16'h8000, 16'h7FFF, 16'hFFFF);
    send_traffic(120);
    drain();
  endtask

  // Random traffic under one idle/stall mix and fresh random gains
  task automatic test_random_phase(input int idle_pct, input int pop_stall_pct,
                                   input int n_bytes);
    write_gain(CFG_ACCEL_GAIN, 24'($urandom_range(GAIN_MAX)));
    write_gain(CFG_RATE_GAIN, 24'($urandom_range(GAIN_MAX)));
    send_idle_pct = idle_pct;
    stall_pct     = pop_stall_pct;
    send_traffic(n_bytes);
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_gain_extremes();
    test_random_phase(0, 0, 350);
    test_random_phase(84, 0, 350);
    test_random_phase(0, 84, 350);
    test_random_phase(21, 21, 350);

    stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/imufd_pkg.sv
rtl/core/imufd_front.sv
rtl/core/imufd_queue.sv
rtl/core/imufd_back.sv
rtl/core/imu_frame_decoder.sv
bench/testbench.sv
